// ===== rtl/cmis_pkg.sv =====
`timescale 1ns / 1ps

package cmis_pkg;

  localparam int VelW     = 32;
  localparam int ImpW     = 31;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;
  localparam int MagW     = 33;
  localparam int ProdW    = MagW + ImpW;
  localparam int DivSteps = 33;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  localparam logic [ImpW-1:0] ImpMax        = {ImpW{1'b1}};
  localparam logic [ImpW-1:0] RstMaxImpulse = {ImpW{1'b1}};
  localparam logic [ImpW-1:0] RstInvInertia = ImpW'(65536);

  typedef enum logic [OpW-1:0] {
    OP_PREPARE = 2'd0,
    OP_APPLY   = 2'd1,
    OP_SOLVE   = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MOTOR_RATE  = 2'd0,
    CFG_MAX_IMPULSE = 2'd1,
    CFG_INV_A       = 2'd2,
    CFG_INV_B       = 2'd3
  } cfg_idx_e;

  function automatic logic signed [VelW-1:0] sat_s32(input logic signed [VelW+1:0] v);
    logic signed [VelW-1:0] r;
    if (v > $signed({3'b000, {(VelW-1){1'b1}}})) begin
      r = {1'b0, {(VelW-1){1'b1}}};
    end else if (v < $signed({3'b111, {(VelW-1){1'b0}}})) begin
      r = {1'b1, {(VelW-1){1'b0}}};
    end else begin
      r = v[VelW-1:0];
    end
    return r;
  endfunction

  function automatic logic [MagW-1:0] abs_s33(input logic signed [MagW-1:0] v);
    logic [MagW-1:0] r;
    if (v[MagW-1]) begin
      r = ~v + MagW'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cmis_if.sv =====
`timescale 1ns / 1ps

interface cmis_req_if import cmis_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         opcode;
  logic signed [VelW-1:0] vel_a;
  logic signed [VelW-1:0] vel_b;
  logic [ImpW-1:0]        dt_coef;

  modport source (output valid, output opcode, output vel_a, output vel_b,
                  output dt_coef, input ready);
  modport sink   (input valid, input opcode, input vel_a, input vel_b,
                  input dt_coef, output ready);
endinterface

interface cmis_rsp_if import cmis_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [VelW-1:0] new_vel_a;
  logic signed [VelW-1:0] new_vel_b;
  logic [ImpW-1:0]        impulse_magnitude;

  modport source (output valid, output new_vel_a, output new_vel_b,
                  output impulse_magnitude, input ready);
  modport sink   (input valid, input new_vel_a, input new_vel_b,
                  input impulse_magnitude, output ready);
endinterface

// ===== rtl/cmis_mul.sv =====
`timescale 1ns / 1ps

module cmis_mul import cmis_pkg::*; (
  input  logic                   clk_i,
  input  logic [MagW-1:0]        mag_a_i,
  input  logic [ImpW-1:0]        mag_b_i,
  input  logic                   neg_i,
  output logic signed [VelW-1:0] res_o
);

  logic [ProdW-1:0]       prod_q;
  logic                   neg_q;
  logic signed [VelW-1:0] res_q;
  logic signed [VelW-1:0] res_d;
  logic [ProdW-17:0]      hi;
  logic [ProdW-16:0]      qn;

  assign hi = prod_q[ProdW-1:16];
  assign qn = {1'b0, hi} + (ProdW-15)'(|prod_q[15:0]);

  // floor the shifted product, then saturate to the signed range
  always_comb begin
    if (neg_q) begin
      if (qn > (ProdW-15)'(64'h8000_0000)) begin
        res_d = {1'b1, {(VelW-1){1'b0}}};
      end else begin
        res_d = VelW'((ProdW-15)'(0) - qn);
      end
    end else begin
      if (hi > (ProdW-16)'(64'h7FFF_FFFF)) begin
        res_d = {1'b0, {(VelW-1){1'b1}}};
      end else begin
        res_d = hi[VelW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(mag_a_i) * ProdW'(mag_b_i);
    neg_q  <= neg_i;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

// ===== rtl/cmis_div.sv =====
`timescale 1ns / 1ps

module cmis_div import cmis_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [VelW-1:0] divisor_i,
  output logic            done_o,
  output logic [ImpW-1:0] quo_o
);

  localparam logic [DivCntW-1:0] LastStep = DivCntW'(DivSteps - 1);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [VelW-1:0]    dvs_q;
  logic [MagW-1:0]    rem_q;
  logic [MagW-1:0]    rem_d;
  logic [MagW-1:0]    quo_q;
  logic [MagW:0]      trial;
  logic               ge;

  // dividend is 2^32: only its top bit is set
  assign trial = {rem_q, cnt_q == '0};
  assign ge    = trial >= (MagW+1)'(dvs_q);
  assign rem_d = ge ? MagW'(trial - (MagW+1)'(dvs_q)) : trial[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[MagW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = (quo_q[MagW-1:ImpW] != '0) ? ImpMax : quo_q[ImpW-1:0];

endmodule

// ===== rtl/clamped_motor_impulse_solver.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake     Payload
// req_i    in   valid/ready   opcode, vel_a, vel_b, dt_coef
// rsp_o    out  valid/ready   new_vel_a, new_vel_b, impulse_magnitude
// cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// One request at a time: clear, apply, solve or prepare; prepare runs the
// 33 steps of the bit-serial divider.
// Apply and solve run three products through one shared two-stage multiplier.
// Reset clears the accumulator and effective inertia and loads register defaults.
// A stalled rsp_o holds the finished result; the next request is taken meanwhile.

module clamped_motor_impulse_solver import cmis_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  cmis_req_if.sink            req_i,
  cmis_rsp_if.source          rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_WR, ST_ISSUE_J, ST_WAIT_J, ST_TAKE_J, ST_CLAMP, ST_DIFF,
    ST_ISSUE_A, ST_ISSUE_B, ST_TAKE_A, ST_TAKE_B, ST_FINISH
  } state_e;

  state_e                 state_q;
  opcode_e                op_q;
  logic signed [VelW-1:0] va_q, vb_q, wr_q, acc_q, old_q;
  logic signed [MagW-1:0] sum_q, d_q;
  logic [ImpW-1:0]        dtc_q, eff_q;
  logic signed [VelW-1:0] rate_q;
  logic [ImpW-1:0]        max_q, inv_a_q, inv_b_q;
  logic                   out_valid_q;
  logic signed [VelW-1:0] out_va_q, out_vb_q;
  logic [ImpW-1:0]        out_mag_q;

  logic                   accept;
  logic                   div_start, div_done;
  logic [ImpW-1:0]        div_quo;
  logic [MagW-1:0]        mul_a;
  logic [ImpW-1:0]        mul_b;
  logic                   mul_neg;
  logic signed [VelW-1:0] mul_res;
  logic signed [MagW-1:0] lim_pos, lim_neg;
  logic [MagW-1:0]        acc_abs;

  assign accept    = req_i.valid && req_i.ready;
  assign div_start = accept && (opcode_e'(req_i.opcode) == OP_PREPARE);
  assign lim_pos   = $signed({2'b00, max_q});
  assign lim_neg   = -lim_pos;
  assign acc_abs   = abs_s33(MagW'(acc_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= '0;
      max_q   <= RstMaxImpulse;
      inv_a_q <= RstInvInertia;
      inv_b_q <= RstInvInertia;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MOTOR_RATE:  rate_q  <= $signed(cfg_data_i[VelW-1:0]);
        CFG_MAX_IMPULSE: max_q   <= cfg_data_i[ImpW-1:0];
        CFG_INV_A:       inv_a_q <= cfg_data_i[ImpW-1:0];
        CFG_INV_B:       inv_b_q <= cfg_data_i[ImpW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_q)
      ST_ISSUE_J: begin
        if (op_q == OP_SOLVE) begin
          mul_a   = abs_s33(MagW'(wr_q));
          mul_b   = eff_q;
          mul_neg = !wr_q[VelW-1] && (wr_q != '0);
        end else begin
          mul_a   = acc_abs;
          mul_b   = dtc_q;
          mul_neg = acc_q[VelW-1];
        end
      end
      ST_ISSUE_A: begin
        mul_a   = abs_s33(d_q);
        mul_b   = inv_a_q;
        mul_neg = d_q[MagW-1];
      end
      ST_ISSUE_B: begin
        mul_a   = abs_s33(d_q);
        mul_b   = inv_b_q;
        mul_neg = d_q[MagW-1];
      end
      default: ;
    endcase
  end

  cmis_mul u_mul (
    .clk_i   (clk_i),
    .mag_a_i (mul_a),
    .mag_b_i (mul_b),
    .neg_i   (mul_neg),
    .res_o   (mul_res)
  );

  cmis_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (VelW'(inv_a_q) + VelW'(inv_b_q)),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      eff_q       <= '0;
    end else begin
      if (rsp_o.valid && rsp_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (opcode_e'(req_i.opcode))
              OP_PREPARE: state_q <= ST_DIV;
              OP_APPLY:   state_q <= ST_ISSUE_J;
              OP_SOLVE:   state_q <= ST_WR;
              OP_CLEAR: begin
                acc_q   <= '0;
                state_q <= ST_FINISH;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            eff_q   <= div_quo;
            state_q <= ST_FINISH;
          end
        end
        ST_WR:      state_q <= ST_ISSUE_J;
        ST_ISSUE_J: state_q <= ST_WAIT_J;
        ST_WAIT_J:  state_q <= ST_TAKE_J;
        ST_TAKE_J:  state_q <= (op_q == OP_SOLVE) ? ST_CLAMP : ST_ISSUE_A;
        ST_CLAMP: begin
          if (sum_q > lim_pos) begin
            acc_q <= VelW'(lim_pos);
          end else if (sum_q < lim_neg) begin
            acc_q <= VelW'(lim_neg);
          end else begin
            acc_q <= VelW'(sum_q);
          end
          state_q <= ST_DIFF;
        end
        ST_DIFF:    state_q <= ST_ISSUE_A;
        ST_ISSUE_A: state_q <= ST_ISSUE_B;
        ST_ISSUE_B: state_q <= ST_TAKE_A;
        ST_TAKE_A:  state_q <= ST_TAKE_B;
        ST_TAKE_B:  state_q <= ST_FINISH;
        ST_FINISH: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q  <= opcode_e'(req_i.opcode);
          va_q  <= req_i.vel_a;
          vb_q  <= req_i.vel_b;
          dtc_q <= req_i.dt_coef;
        end
      end
      ST_WR:     wr_q  <= sat_s32((VelW+2)'(vb_q) - (VelW+2)'(va_q) + (VelW+2)'(rate_q));
      ST_TAKE_J: begin
        sum_q <= MagW'(acc_q) + MagW'(mul_res);
        d_q   <= MagW'(mul_res);
      end
      ST_CLAMP:  old_q <= acc_q;
      ST_DIFF:   d_q   <= MagW'(acc_q) - MagW'(old_q);
      ST_TAKE_A: va_q  <= sat_s32((VelW+2)'(va_q) - (VelW+2)'(mul_res));
      ST_TAKE_B: vb_q  <= sat_s32((VelW+2)'(vb_q) + (VelW+2)'(mul_res));
      ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_va_q  <= va_q;
          out_vb_q  <= vb_q;
          out_mag_q <= acc_abs[ImpW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign req_i.ready             = (state_q == ST_IDLE);
  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.new_vel_a         = out_va_q;
  assign rsp_o.new_vel_b         = out_vb_q;
  assign rsp_o.impulse_magnitude = out_mag_q;

  a_acc_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIFF |-> (acc_q <= $signed({1'b0, max_q}))
                        && (acc_q >= -$signed({1'b0, max_q})))
    else $error("accumulator outside impulse limit");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside prepare");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("request taken while busy");

  a_clear_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (opcode_e'(req_i.opcode) == OP_CLEAR) |=> acc_q == '0)
    else $error("accumulator not cleared");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside finish");

endmodule
